[rtl/cpr_pkg.sv]
// Shared constants and types for the clock page replacement block.
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int NUM_PAGES  = 128;
  localparam int MAX_FRAMES = 128;

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W   = 8;
  localparam int HITS_W  = 32;

  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  waddr;
    logic [FRAME_W-1:0] wdata;
    logic [PAGE_W-1:0]  raddr;
  } map_req_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] waddr;
    logic [PAGE_W-1:0]  wdata;
    logic [FRAME_W-1:0] raddr;
  } fp_req_t;

  typedef struct packed {
    logic               hit;
    logic               victim_valid;
    logic [PAGE_W-1:0]  victim_page;
    logic [FRAME_W-1:0] frame_index;
    logic [HITS_W-1:0]  hit_count;
  } result_t;

endpackage

[rtl/cpr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cpr_ctrl.sv]
// Sequencer for lookup, fill and clock sweep, with resident and referenced bits.
`timescale 1ns / 1ps

module cpr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cpr_pkg::PAGE_W-1:0]   page_number,
  input  logic [cpr_pkg::CNT_W-1:0]    nf,
  output cpr_pkg::map_req_t            map_req,
  input  logic [cpr_pkg::FRAME_W-1:0]  map_rdata,
  output cpr_pkg::fp_req_t             fp_req,
  input  logic [cpr_pkg::PAGE_W-1:0]   fp_rdata,
  output cpr_pkg::result_t             res,
  output logic                         res_valid,
  input  logic                         res_taken
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_EVICT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                        state;
  logic [cpr_pkg::NUM_PAGES-1:0]  map_valid;
  logic [cpr_pkg::MAX_FRAMES-1:0] ref_bits;
  logic [cpr_pkg::FRAME_W-1:0]    hand;
  logic [cpr_pkg::CNT_W-1:0]      fill_count;
  logic [cpr_pkg::HITS_W-1:0]     hit_counter;

  logic [cpr_pkg::PAGE_W-1:0]     page;
  logic                           hit;
  logic                           victim_valid;
  logic [cpr_pkg::PAGE_W-1:0]     victim_page;
  logic [cpr_pkg::FRAME_W-1:0]    frame;

  logic                           accept;
  logic                           can_fill;
  logic [cpr_pkg::FRAME_W-1:0]    hand_inc;
  logic [cpr_pkg::FRAME_W-1:0]    fill_frame;

  assign accept     = in_valid && (state == S_IDLE);
  assign in_stall   = (state != S_IDLE);
  assign can_fill   = (fill_count < nf);
  assign fill_frame = fill_count[cpr_pkg::FRAME_W-1:0];
  assign hand_inc   = ((cpr_pkg::CNT_W'(hand) + cpr_pkg::CNT_W'(1)) == nf) ? '0
                      : hand + cpr_pkg::FRAME_W'(1);

  always_comb begin
    map_req.we    = 1'b0;
    map_req.waddr = page;
    map_req.wdata = hand;
    map_req.raddr = (state == S_IDLE) ? page_number : page;
    fp_req.we     = 1'b0;
    fp_req.waddr  = hand;
    fp_req.wdata  = page;
    fp_req.raddr  = hand;
    case (state)
      S_LOOKUP: begin
        if (!map_valid[page] && can_fill) begin
          map_req.we    = 1'b1;
          map_req.wdata = fill_frame;
          fp_req.we     = 1'b1;
          fp_req.waddr  = fill_frame;
        end
      end
      S_EVICT: begin
        map_req.we = 1'b1;
        fp_req.we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      map_valid   <= '0;
      ref_bits    <= '0;
      hand        <= '0;
      fill_count  <= '0;
      hit_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            page  <= page_number;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          victim_valid <= 1'b0;
          victim_page  <= '0;
          if (map_valid[page]) begin
            hit                 <= 1'b1;
            frame               <= map_rdata;
            ref_bits[map_rdata] <= 1'b1;
            if (hit_counter != '1) begin
              hit_counter <= hit_counter + cpr_pkg::HITS_W'(1);
            end
            state <= S_FINISH;
          end else if (can_fill) begin
            hit                  <= 1'b0;
            frame                <= fill_frame;
            ref_bits[fill_frame] <= 1'b0;
            map_valid[page]      <= 1'b1;
            fill_count           <= fill_count + cpr_pkg::CNT_W'(1);
            state                <= S_FINISH;
          end else begin
            hit <= 1'b0;
            if (cpr_pkg::CNT_W'(hand) >= nf) begin
              hand <= '0;
            end
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (ref_bits[hand]) begin
            ref_bits[hand] <= 1'b0;
            hand           <= hand_inc;
          end else begin
            frame <= hand;
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          map_valid[fp_rdata] <= 1'b0;
          map_valid[page]     <= 1'b1;
          victim_valid        <= 1'b1;
          victim_page         <= fp_rdata;
          ref_bits[hand]      <= 1'b0;
          hand                <= hand_inc;
          state               <= S_FINISH;
        end
        S_FINISH: begin
          if (res_taken) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid        = (state == S_FINISH);
  assign res.hit          = hit;
  assign res.victim_valid = victim_valid;
  assign res.victim_page  = victim_page;
  assign res.frame_index  = frame;
  assign res.hit_count    = hit_counter;

endmodule

[rtl/clock_page_replacement.sv]
// Top level of the clock (second chance) page replacement block.
`timescale 1ns / 1ps

// Each transaction on the input channel is one page reference; each output
// transaction reports hit, evicted page, frame now holding the page and the
// saturating hit count. One reference is processed at a time. A hit or a
// fill into a free frame passes through lookup and finish; a miss with
// eviction passes through lookup, a sweep past k frames whose referenced bit
// the hand clears on its way (k at most the effective frame count), evict
// and finish. A result waits in finish while out_stall holds the output
// register. The sweep visits one frame per cycle through the shared
// referenced-bit check and the frame-to-page RAM read port. Resident and
// referenced bits clear at reset, so no clearing pass is needed.
// frames_in_use resets to 128; 0 acts as 1 and values above the frame count
// act as the frame count. Write it only while the block is idle.

module clock_page_replacement (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cpr_pkg::PAGE_W-1:0]           page_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic                                 victim_valid,
  output logic [cpr_pkg::PAGE_W-1:0]           victim_page,
  output logic [cpr_pkg::FRAME_W-1:0]          frame_index,
  output logic [cpr_pkg::HITS_W-1:0]           hit_count,
  input  logic                                 wr_en,
  input  logic [cpr_pkg::CFG_W-1:0]            wr_data
);

  logic [cpr_pkg::CFG_W-1:0]   frames_in_use;
  logic [cpr_pkg::CNT_W-1:0]   nf;
  cpr_pkg::map_req_t           map_req;
  cpr_pkg::fp_req_t            fp_req;
  logic [cpr_pkg::FRAME_W-1:0] map_rdata;
  logic [cpr_pkg::PAGE_W-1:0]  fp_rdata;
  cpr_pkg::result_t            res;
  logic                        res_valid;
  logic                        res_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= cpr_pkg::CFG_W'(128);
    end else if (wr_en) begin
      frames_in_use <= wr_data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      nf = cpr_pkg::CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(cpr_pkg::MAX_FRAMES)) begin
      nf = cpr_pkg::CNT_W'(cpr_pkg::MAX_FRAMES);
    end else begin
      nf = cpr_pkg::CNT_W'(frames_in_use);
    end
  end

  cpr_ram #(
    .WIDTH(cpr_pkg::FRAME_W),
    .DEPTH(cpr_pkg::NUM_PAGES)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_req.we),
    .waddr(map_req.waddr),
    .wdata(map_req.wdata),
    .raddr(map_req.raddr),
    .rdata(map_rdata)
  );

  cpr_ram #(
    .WIDTH(cpr_pkg::PAGE_W),
    .DEPTH(cpr_pkg::MAX_FRAMES)
  ) u_fp_ram (
    .clk  (clk),
    .we   (fp_req.we),
    .waddr(fp_req.waddr),
    .wdata(fp_req.wdata),
    .raddr(fp_req.raddr),
    .rdata(fp_rdata)
  );

  cpr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .page_number(page_number),
    .nf         (nf),
    .map_req    (map_req),
    .map_rdata  (map_rdata),
    .fp_req     (fp_req),
    .fp_rdata   (fp_rdata),
    .res        (res),
    .res_valid  (res_valid),
    .res_taken  (res_taken)
  );

  assign res_taken = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      hit          <= res.hit;
      victim_valid <= res.victim_valid;
      victim_page  <= res.victim_page;
      frame_index  <= res.frame_index;
      hit_count    <= res.hit_count;
    end
  end

endmodule
